[src/assert_macros.svh]
// Assertion macros used by the back end of the segmenter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, disabled while rst is high.
`define ASSERT_AT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never hold on a rising edge of clk.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_AT(label, !(cond), msg)

`endif

[src/tsws_pkg.sv]
// Types and constants shared by the TCP send window segmenter modules.
package tsws_pkg;

  localparam int WIN_W = 16;
  localparam int SEQ_W = 32;
  localparam int LEN_W = 24;
  localparam int BUF_W = 5;
  localparam int MSS_W = 16;
  localparam int CNT_W = 5;
  localparam int BURST_CAP = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = 1;

  localparam logic [MSS_W-1:0] MSS_RESET = 16'd1460;

  localparam logic [1:0] FUNC_INIT   = 2'd0;
  localparam logic [1:0] FUNC_UPDATE = 2'd1;
  localparam logic [1:0] FUNC_LOAD   = 2'd2;
  localparam logic [1:0] FUNC_SEND   = 2'd3;

  typedef enum logic [1:0] {
    CMD_INIT,
    CMD_UPDATE,
    CMD_LOAD,
    CMD_SEND
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [WIN_W-1:0]  window_size;
    logic [SEQ_W-1:0]  peer_seq;
    logic [SEQ_W-1:0]  peer_ack;
    logic [SEQ_W-1:0]  start_seq;
    logic [LEN_W-1:0]  data_length;
    logic [BUF_W-1:0]  buffers_free;
    logic              probe_allowed;
  } cmd_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } qstat_t;

endpackage

[src/tcp_send_window_segmenter_unit.sv]
// Top level of the TCP send window segmenter.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | func, window_size, peer_seq, peer_ack,
//           |           |                      | start_seq, data_length, buffers_free,
//           |           |                      | probe_allowed
//   out     | output    | out_valid/out_stall  | segment_seq, segment_length, push_flag,
//           |           |                      | last_segment
//   cfg     | input     | cfg_we               | cfg_wdata (max_segment_size)
//
// A transaction is held in the input register, then waits in a two-entry queue.
// The back end takes window and length commands straight from the queue head; a send
// attempt emits segments one after another, bounded by the burst limit.
// Reset clears the connection state and sets the maximum segment size to 1460.
// A stalled output holds the back end; the queue lets the front keep accepting until it fills.
module tcp_send_window_segmenter_unit import tsws_pkg::*; #(
  parameter int MAX_BURST = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [MSS_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        func,
  input  logic [WIN_W-1:0]  window_size,
  input  logic [SEQ_W-1:0]  peer_seq,
  input  logic [SEQ_W-1:0]  peer_ack,
  input  logic [SEQ_W-1:0]  start_seq,
  input  logic [LEN_W-1:0]  data_length,
  input  logic [BUF_W-1:0]  buffers_free,
  input  logic              probe_allowed,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SEQ_W-1:0]  segment_seq,
  output logic [WIN_W-1:0]  segment_length,
  output logic              push_flag,
  output logic              last_segment
);

  logic [MSS_W-1:0] mss;
  qstat_t           qstat;
  logic             push;
  logic             pop;
  cmd_t             front_cmd;
  cmd_t             head;

  always_ff @(posedge clk) begin
    if (rst) begin
      mss <= MSS_RESET;
    end else if (cfg_we) begin
      mss <= cfg_wdata;
    end
  end

  tsws_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .window_size   (window_size),
    .peer_seq      (peer_seq),
    .peer_ack      (peer_ack),
    .start_seq     (start_seq),
    .data_length   (data_length),
    .buffers_free  (buffers_free),
    .probe_allowed (probe_allowed),
    .qstat         (qstat),
    .push          (push),
    .cmd           (front_cmd)
  );

  tsws_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (front_cmd),
    .pop    (pop),
    .head   (head),
    .qstat  (qstat)
  );

  tsws_back #(
    .MAX_BURST (MAX_BURST)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .mss            (mss),
    .qstat          (qstat),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .segment_seq    (segment_seq),
    .segment_length (segment_length),
    .push_flag      (push_flag),
    .last_segment   (last_segment)
  );

endmodule

[src/tsws_front.sv]
// Front end: registers incoming transactions and classifies them into commands.
module tsws_front import tsws_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        func,
  input  logic [WIN_W-1:0]  window_size,
  input  logic [SEQ_W-1:0]  peer_seq,
  input  logic [SEQ_W-1:0]  peer_ack,
  input  logic [SEQ_W-1:0]  start_seq,
  input  logic [LEN_W-1:0]  data_length,
  input  logic [BUF_W-1:0]  buffers_free,
  input  logic              probe_allowed,
  input  qstat_t            qstat,
  output logic              push,
  output cmd_t              cmd
);

  logic      hold_valid;
  logic      accept;
  cmd_kind_t kind;

  assign push     = hold_valid && !qstat.full;
  assign in_stall = hold_valid && qstat.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    unique case (func)
      FUNC_INIT:   kind = CMD_INIT;
      FUNC_UPDATE: kind = CMD_UPDATE;
      FUNC_LOAD:   kind = CMD_LOAD;
      FUNC_SEND:   kind = CMD_SEND;
      default:     kind = CMD_SEND;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
    if (accept) begin
      cmd.kind          <= kind;
      cmd.window_size   <= window_size;
      cmd.peer_seq      <= peer_seq;
      cmd.peer_ack      <= peer_ack;
      cmd.start_seq     <= start_seq;
      cmd.data_length   <= data_length;
      cmd.buffers_free  <= buffers_free;
      cmd.probe_allowed <= probe_allowed;
    end
  end

endmodule

[src/tsws_queue.sv]
// Short command queue between the front end and the segmenting back end.
module tsws_queue import tsws_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  cmd_t   wr_cmd,
  input  logic   pop,
  output cmd_t   head,
  output qstat_t qstat
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign qstat.full      = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign qstat.not_empty = (count != '0);
  assign do_push = push && !qstat.full;
  assign do_pop  = pop && qstat.not_empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

endmodule

[src/tsws_back.sv]
// Back end: connection state, window update checks and the segmenting loop.
`include "assert_macros.svh"
module tsws_back import tsws_pkg::*; #(
  parameter int MAX_BURST = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [MSS_W-1:0]  mss,
  input  qstat_t            qstat,
  input  cmd_t              head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SEQ_W-1:0]  segment_seq,
  output logic [WIN_W-1:0]  segment_length,
  output logic              push_flag,
  output logic              last_segment
);

  localparam int LIMIT = (MAX_BURST < BURST_CAP) ? MAX_BURST : BURST_CAP;
  localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(LIMIT);

  typedef enum logic {ST_TAKE, ST_SEG} state_t;

  state_t            st;
  logic [WIN_W-1:0]  send_window;
  logic [SEQ_W-1:0]  wu_seq;
  logic [SEQ_W-1:0]  wu_ack;
  logic [SEQ_W-1:0]  next_seq;
  logic [LEN_W-1:0]  pending_bytes;
  logic [BUF_W-1:0]  bufs;
  logic              probe;
  logic [CNT_W-1:0]  cnt;
  logic              first;

  logic              out_free;
  logic              stale;
  logic [WIN_W-1:0]  win_or_pend;
  logic [WIN_W-1:0]  seg_len;
  logic [LEN_W-1:0]  pend_after;
  logic [WIN_W-1:0]  win_after;
  logic [CNT_W-1:0]  cnt_inc;
  logic              probe_case;
  logic              probe_go;
  logic              go;
  logic              seg_last;
  logic              emit;

  function automatic logic serial_before(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] diff;
    diff = a - b;
    return diff[SEQ_W-1];
  endfunction

  assign out_free = !out_valid || !out_stall;
  assign pop      = (st == ST_TAKE) && qstat.not_empty;

  assign stale = serial_before(head.peer_seq, wu_seq) ||
                 ((head.peer_seq == wu_seq) && serial_before(head.peer_ack, wu_ack));

  // Segment length is min(window, pending, MSS); a probe is always one byte.
  assign win_or_pend = (pending_bytes < {{(LEN_W-WIN_W){1'b0}}, send_window}) ?
                       pending_bytes[WIN_W-1:0] : send_window;
  assign probe_case  = first && (send_window == '0);
  assign seg_len     = probe_case ? WIN_W'(1) : ((mss < win_or_pend) ? mss : win_or_pend);
  assign pend_after  = pending_bytes - {{(LEN_W-WIN_W){1'b0}}, seg_len};
  assign win_after   = send_window - seg_len;
  assign cnt_inc     = cnt + 1'b1;

  assign probe_go = probe_case && (pending_bytes != '0) && probe && (bufs != '0);
  assign go       = !probe_case && (pending_bytes != '0) && (send_window != '0) &&
                    (cnt < LIMIT_C) && ({1'b0, cnt} < {1'b0, bufs}) && (mss != '0);
  assign seg_last = !((pend_after != '0) && (win_after != '0) && (cnt_inc < LIMIT_C) &&
                      (cnt_inc < bufs));
  assign emit     = (st == ST_SEG) && out_free && (probe_go || go);

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= ST_TAKE;
      out_valid     <= 1'b0;
      send_window   <= '0;
      wu_seq        <= '0;
      wu_ack        <= '0;
      next_seq      <= '0;
      pending_bytes <= '0;
      cnt           <= '0;
      first         <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        ST_TAKE: begin
          if (pop) begin
            unique case (head.kind)
              CMD_INIT: begin
                send_window <= head.window_size;
                wu_seq      <= head.peer_seq;
                wu_ack      <= head.peer_ack;
                next_seq    <= head.start_seq;
              end
              CMD_UPDATE: begin
                if (!stale) begin
                  send_window <= head.window_size;
                  wu_seq      <= head.peer_seq;
                  wu_ack      <= head.peer_ack;
                end
              end
              CMD_LOAD: begin
                pending_bytes <= head.data_length;
              end
              CMD_SEND: begin
                bufs  <= head.buffers_free;
                probe <= head.probe_allowed;
                cnt   <= '0;
                first <= 1'b1;
                st    <= ST_SEG;
              end
              default: begin
                st <= ST_TAKE;
              end
            endcase
          end
        end
        ST_SEG: begin
          if (out_free) begin
            first <= 1'b0;
            if (emit) begin
              out_valid      <= 1'b1;
              segment_seq    <= next_seq;
              segment_length <= seg_len;
              push_flag      <= (pend_after == '0);
              last_segment   <= probe_case || seg_last;
              pending_bytes  <= pend_after;
              next_seq       <= next_seq + {{(SEQ_W-WIN_W){1'b0}}, seg_len};
              cnt            <= cnt_inc;
              if (!probe_case) begin
                send_window <= win_after;
              end
              if (probe_case || seg_last) begin
                st <= ST_TAKE;
              end
            end else begin
              st <= ST_TAKE;
            end
          end
        end
        default: begin
          st <= ST_TAKE;
        end
      endcase
    end
  end

  `ASSERT_AT(a_len_nonzero, out_valid |-> (segment_length != '0), "segment of zero bytes")
  `ASSERT_AT(a_push_empties, (emit && (pend_after == '0)) |=> (pending_bytes == '0), "push flag with bytes left")
  `ASSERT_AT(a_fits_window, (emit && !probe_case) |-> (seg_len <= send_window), "segment exceeds window")
  `ASSERT_NEVER(a_burst_bound, cnt > LIMIT_C, "burst count beyond limit")

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the TCP send window segmenter top level.
module tb;
  import tsws_pkg::*;

  localparam int DRAIN_CYCLES = 32;
  localparam int STUCK_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [WIN_W-1:0] len;
    logic             push;
    logic             last;
  } segment_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [MSS_W-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_stall;
  cmd_t             drv;
  logic             out_valid;
  logic             out_stall;
  logic [SEQ_W-1:0] segment_seq;
  logic [WIN_W-1:0] segment_length;
  logic             push_flag;
  logic             last_segment;

  // Predicted connection state.
  logic [WIN_W-1:0] snd_wnd;
  logic [SEQ_W-1:0] wnd_seq;
  logic [SEQ_W-1:0] wnd_ack;
  logic [SEQ_W-1:0] snd_nxt;
  logic [LEN_W-1:0] unsent_bytes;
  logic [MSS_W-1:0] mss_reg;

  segment_t expected_segs[$];
  int       err_count;
  int       stuck_cycles;
  int       stall_left;
  bit       idle_on;

  tcp_send_window_segmenter_unit #(
    .MAX_BURST(BURST_CAP)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (drv.kind),
    .window_size   (drv.window_size),
    .peer_seq      (drv.peer_seq),
    .peer_ack      (drv.peer_ack),
    .start_seq     (drv.start_seq),
    .data_length   (drv.data_length),
    .buffers_free  (drv.buffers_free),
    .probe_allowed (drv.probe_allowed),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .segment_seq   (segment_seq),
    .segment_length(segment_length),
    .push_flag     (push_flag),
    .last_segment  (last_segment)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit seq_older(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] diff;
    diff = a - b;
    return diff[SEQ_W-1];
  endfunction

  task automatic emit_segment(logic [LEN_W-1:0] len);
    segment_t s;
    unsent_bytes = unsent_bytes - len;
    s.seq = snd_nxt;
    s.len = len[WIN_W-1:0];
    s.push = (unsent_bytes == '0);
    s.last = 1'b0;
    snd_nxt = snd_nxt + SEQ_W'(len);
    expected_segs.push_back(s);
  endtask

  // Advances the connection state for one accepted transaction and queues
  // the segments that it produces.
  task automatic cut_segments(cmd_t c);
    int n;
    logic [LEN_W-1:0] len;
    n = 0;
    case (c.kind)
      CMD_INIT: begin
        snd_wnd = c.window_size;
        wnd_seq = c.peer_seq;
        wnd_ack = c.peer_ack;
        snd_nxt = c.start_seq;
      end
      CMD_UPDATE: begin
        if (!(seq_older(c.peer_seq, wnd_seq) ||
              (c.peer_seq == wnd_seq && seq_older(c.peer_ack, wnd_ack)))) begin
          snd_wnd = c.window_size;
          wnd_seq = c.peer_seq;
          wnd_ack = c.peer_ack;
        end
      end
      CMD_LOAD: unsent_bytes = c.data_length;
      default: begin
        if (unsent_bytes != '0 && snd_wnd == '0) begin
          // A closed window gets a single one-byte probe that leaves it closed.
          if (c.probe_allowed && c.buffers_free != '0) begin
            emit_segment(LEN_W'(1));
            n = 1;
          end
        end else begin
          while (unsent_bytes != '0 && snd_wnd != '0 && n < BURST_CAP &&
                 n < int'(c.buffers_free) && mss_reg != '0) begin
            len = LEN_W'(snd_wnd);
            if (unsent_bytes < len) len = unsent_bytes;
            if (LEN_W'(mss_reg) < len) len = LEN_W'(mss_reg);
            emit_segment(len);
            snd_wnd = snd_wnd - len[WIN_W-1:0];
            n++;
          end
        end
        if (n > 0) expected_segs[expected_segs.size()-1].last = 1'b1;
      end
    endcase
  endtask

  // Output side: random stall bursts while idling is enabled.
  initial begin
    out_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) stall_left--;
      else if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 13);
      out_stall <= (stall_left > 0);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_segs.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("unexpected segment: seq %h len %0d push %b last %b",
                   segment_seq, segment_length, push_flag, last_segment);
      end else begin
        segment_t exp_seg;
        exp_seg = expected_segs.pop_front();
        if (segment_seq !== exp_seg.seq || segment_length !== exp_seg.len ||
            push_flag !== exp_seg.push || last_segment !== exp_seg.last) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display({"segment mismatch: expected seq %h len %0d push %b last %b, ",
                      "got seq %h len %0d push %b last %b"},
                     exp_seg.seq, exp_seg.len, exp_seg.push, exp_seg.last,
                     segment_seq, segment_length, push_flag, last_segment);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // Sends one transaction, holding it until accepted, then updates the prediction.
  task automatic send_cmd(cmd_t c);
    int gap;
    gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 13) : 0;
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    drv <= c;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    cut_segments(c);
  endtask

  task automatic release_input();
    @(negedge clk) in_valid <= 1'b0;
  endtask

  task automatic wait_results();
    release_input();
    while (expected_segs.size() != 0) @(posedge clk);
  endtask

  // Commands that produce no segment may still be in flight, so let them drain.
  task automatic wait_idle();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mss(logic [MSS_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk) cfg_we <= 1'b0;
    mss_reg = value;
  endtask

  function automatic cmd_t noise_cmd();
    cmd_t c;
    c.kind = cmd_kind_t'($urandom_range(0, 3));
    c.window_size = WIN_W'($urandom);
    c.peer_seq = $urandom;
    c.peer_ack = $urandom;
    c.start_seq = $urandom;
    c.data_length = LEN_W'($urandom);
    c.buffers_free = BUF_W'($urandom_range(0, 16));
    c.probe_allowed = 1'($urandom);
    return c;
  endfunction

  task automatic do_init(logic [WIN_W-1:0] win, logic [SEQ_W-1:0] pseq,
                         logic [SEQ_W-1:0] pack, logic [SEQ_W-1:0] sseq);
    cmd_t c;
    c = noise_cmd();
    c.kind = CMD_INIT;
    c.window_size = win;
    c.peer_seq = pseq;
    c.peer_ack = pack;
    c.start_seq = sseq;
    send_cmd(c);
  endtask

  task automatic do_update(logic [WIN_W-1:0] win, logic [SEQ_W-1:0] pseq,
                           logic [SEQ_W-1:0] pack);
    cmd_t c;
    c = noise_cmd();
    c.kind = CMD_UPDATE;
    c.window_size = win;
    c.peer_seq = pseq;
    c.peer_ack = pack;
    send_cmd(c);
  endtask

  task automatic do_load(logic [LEN_W-1:0] len);
    cmd_t c;
    c = noise_cmd();
    c.kind = CMD_LOAD;
    c.data_length = len;
    send_cmd(c);
  endtask

  task automatic do_send(logic [BUF_W-1:0] bufs, logic probe);
    cmd_t c;
    c = noise_cmd();
    c.kind = CMD_SEND;
    c.buffers_free = bufs;
    c.probe_allowed = probe;
    send_cmd(c);
  endtask

  function automatic logic [WIN_W-1:0] rand_window();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r < 6) return WIN_W'($urandom_range(1, 3000));
    return WIN_W'($urandom);
  endfunction

  function automatic logic [LEN_W-1:0] rand_length();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r < 18) return LEN_W'($urandom_range(1, 6000));
    return LEN_W'($urandom);
  endfunction

  // Mostly sensible connection traffic, with stale updates and pure noise mixed in.
  function automatic cmd_t random_cmd();
    cmd_t c;
    int r;
    c = noise_cmd();
    r = $urandom_range(0, 99);
    if (r < 8) begin
      c.kind = CMD_INIT;
      c.window_size = rand_window();
    end else if (r < 30) begin
      c.kind = CMD_UPDATE;
      c.window_size = rand_window();
      if (r < 26) begin
        c.peer_seq = wnd_seq + $urandom_range(0, 3);
        c.peer_ack = (c.peer_seq == wnd_seq) ? wnd_ack + $urandom_range(0, 2000) : $urandom;
      end else if (r < 28) begin
        c.peer_seq = wnd_seq - $urandom_range(1, 1000);
      end else begin
        c.peer_seq = wnd_seq;
        c.peer_ack = wnd_ack - $urandom_range(1, 1000);
      end
    end else if (r < 50) begin
      c.kind = CMD_LOAD;
      c.data_length = rand_length();
    end else if (r < 92) begin
      c.kind = CMD_SEND;
    end
    return c;
  endfunction

  task automatic test_nothing_pending();
    do_send(5'd16, 1'b1);
  endtask

  // Default segment size, push on the emptying segment, sequence wrap.
  task automatic test_init_and_wrap();
    do_init(16'd5000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FF00);
    do_load(24'd4000);
    do_send(5'd16, 1'b0);
  endtask

  task automatic test_stale_updates();
    do_update(16'hFFFF, 32'h7FFF_FFFE, 32'hFFFF_FFFF);
    do_update(16'hFFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFE);
    do_update(16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    do_update(16'h0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_closed_window();
    do_load(24'd10);
    do_send(5'd16, 1'b0);
    do_send(5'd0, 1'b1);
    do_send(5'd5, 1'b1);
  endtask

  task automatic test_buffer_limit();
    do_update(16'hFFFF, 32'h8000_0000, 32'h0000_0000);
    do_load(24'd5000);
    do_send(5'd1, 1'b1);
    do_send(5'd2, 1'b0);
    do_send(5'd0, 1'b0);
  endtask

  task automatic test_mss_extremes();
    wait_idle();
    write_mss(16'd0);
    do_send(5'd16, 1'b1);
    do_update(16'h0000, 32'h8000_0001, 32'h0000_0000);
    do_send(5'd16, 1'b1);
    wait_idle();
    write_mss(16'd1);
    do_init(16'hFFFF, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFF8);
    do_load(24'd20);
    do_send(5'd16, 1'b1);
    wait_idle();
    write_mss(16'hFFFF);
    do_load(24'hFF_FFFF);
    do_init(16'hFFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    do_send(5'd16, 1'b0);
  endtask

  task automatic test_random_phase(logic [MSS_W-1:0] mss, int count, bit with_pause);
    wait_idle();
    write_mss(mss);
    do_init(rand_window() | 16'd1, $urandom, $urandom, $urandom);
    for (int i = 1; i < count; i++) begin
      if (with_pause && i == count / 2) wait_results();
      send_cmd(random_cmd());
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    drv = '0;
    idle_on = 1'b1;
    err_count = 0;
    snd_wnd = '0;
    wnd_seq = '0;
    wnd_ack = '0;
    snd_nxt = '0;
    unsent_bytes = '0;
    mss_reg = MSS_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_nothing_pending();
    test_init_and_wrap();
    test_stale_updates();
    test_closed_window();
    test_buffer_limit();
    test_mss_extremes();
    test_random_phase(16'd1460, 64, 1'b0);
    test_random_phase(16'($urandom_range(1, 64)), 64, 1'b1);
    test_random_phase(16'd536, 64, 1'b0);
    test_random_phase(16'hFFFF, 64, 1'b0);
    test_random_phase(16'($urandom_range(1, 3000)), 64, 1'b0);
    idle_on = 1'b0;
    test_random_phase(16'd1, 40, 1'b0);

    wait_idle();
    if (err_count == 0 && expected_segs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
